// ----- rtl/joystick_to_pointer_motion_assert.svh -----
// Assertion macros used by the joystick-to-pointer merge stage.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef JOYSTICK_TO_POINTER_MOTION_ASSERT_SVH
`define JOYSTICK_TO_POINTER_MOTION_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define JTPM_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("jtpm assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define JTPM_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jtpm assertion failed");

`endif

// ----- rtl/jtpm_pkg.sv -----
// Shared types and constants for the joystick-to-pointer motion block.
// Used by the divider, the axis lanes, the merge stage and the top level.
package jtpm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 14;
   localparam int SPEED_W    = 24;
   localparam int MOVE_W     = 8;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = 5;

   // 1.0 in Q1.16.
   localparam logic [FRAC_W:0] Q16_ONE = 17'h10000;

   // Item opcodes.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_PAUSE  = 2'd1;
   localparam logic [1:0] OP_RESUME = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_Y = 3'd7;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0] RST_REACH    = 16'd32767;
   localparam logic [GAIN_W-1:0]   RST_GAIN_X   = 14'd3840;
   localparam logic [GAIN_W-1:0]   RST_GAIN_Y   = 14'd5632;
   localparam logic [FRAC_W-1:0]   RST_DEADBAND = 16'd9830;

   // Command from the top-level sequencer to the merge stage.
   typedef struct packed {
      logic start;
      logic clear;
   } merge_cmd_type;

endpackage

// ----- rtl/jtpm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, 16 fraction bits.
// Requires num < den; depends on jtpm_pkg.
module jtpm_div
   import jtpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FRAC_W:0]   num,
   input  logic [FRAC_W:0]   den,
   output logic              done,
   output logic [FRAC_W-1:0] quot
);

   logic [FRAC_W:0]    rem_ff, rem_in;
   logic [FRAC_W:0]    den_ff;
   logic [FRAC_W-1:0]  quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic               done_in;
   logic [FRAC_W:0]    shifted;
   logic               take;

   // The partial remainder stays below den, so one shift fits in 17 bits.
   always_comb begin
      shifted = {rem_ff[FRAC_W-1:0], 1'b0};
      take    = (shifted >= den_ff);
      rem_in  = take ? (shifted - den_ff) : shifted;
      done_in = !start && busy_ff && (cnt_ff == DIV_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= done_in;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/jtpm_lane.sv -----
// One axis lane: center, normalize, dead zone, remap, square, gain, sign.
// Uses jtpm_div for both divisions; depends on jtpm_pkg.
module jtpm_lane
   import jtpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [SAMPLE_W-1:0] center,
   input  logic [SAMPLE_W-1:0]        reach,
   input  logic [GAIN_W-1:0]          gain,
   input  logic [FRAC_W-1:0]          deadband,
   output logic                       done,
   output logic [SPEED_W-1:0]         speed
);

   typedef enum logic [2:0] {
      L_IDLE, L_NORM, L_DIV1, L_DZ, L_DIV2, L_SQ, L_GAIN
   } state_type;

   state_type state_ff;

   logic [SAMPLE_W-1:0] mag_ff;
   logic                neg_ff;
   logic [FRAC_W:0]     norm_ff;
   logic [FRAC_W:0]     remap_ff;
   logic [FRAC_W:0]     sq_ff;
   logic [SPEED_W-1:0]  speed_ff;
   logic                done_ff;
   logic                done_in;

   logic [SAMPLE_W:0]     diff;
   logic [SAMPLE_W:0]     mag_in;
   logic [FRAC_W:0]       hr;
   logic [FRAC_W:0]       dz;
   logic [FRAC_W:0]       den2;
   logic [FRAC_W:0]       num2;
   logic                  clamp;
   logic                  below;
   logic                  full;
   logic                  div_start;
   logic [FRAC_W:0]       div_num;
   logic [FRAC_W:0]       div_den;
   logic                  div_done;
   logic [FRAC_W-1:0]     div_quot;
   logic [2*FRAC_W+1:0]   sq_prod;
   logic [FRAC_W+GAIN_W:0] gain_prod;
   logic [SPEED_W-2:0]    spd;

   always_comb begin
      diff   = {sample[SAMPLE_W-1], sample} - {center[SAMPLE_W-1], center};
      mag_in = diff[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - diff) : diff;
      hr     = (reach == '0) ? (FRAC_W+1)'(1) : {1'b0, reach};
      dz     = {1'b0, deadband};
      den2   = Q16_ONE - dz;
      num2   = norm_ff - dz;
      // A magnitude at or past the half range saturates at full deflection.
      clamp  = ({1'b0, mag_ff} >= hr);
      below  = (norm_ff < dz);
      full   = (num2 >= den2);
      div_start = ((state_ff == L_NORM) && !clamp) ||
                  ((state_ff == L_DZ) && !below && !full);
      div_num = (state_ff == L_NORM) ? {1'b0, mag_ff} : num2;
      div_den = (state_ff == L_NORM) ? hr : den2;
      sq_prod   = remap_ff * remap_ff;
      gain_prod = {{GAIN_W{1'b0}}, sq_ff} * {{(FRAC_W+1){1'b0}}, gain};
      spd       = gain_prod[FRAC_W+GAIN_W:8];
      done_in   = ((state_ff == L_DZ) && below) || (state_ff == L_GAIN);
   end

   jtpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  mag_ff   <= mag_in[SAMPLE_W-1:0];
                  neg_ff   <= diff[SAMPLE_W];
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               if (clamp) begin
                  norm_ff  <= Q16_ONE;
                  state_ff <= L_DZ;
               end else begin
                  state_ff <= L_DIV1;
               end
            end
            L_DIV1: begin
               if (div_done) begin
                  norm_ff  <= {1'b0, div_quot};
                  state_ff <= L_DZ;
               end
            end
            L_DZ: begin
               if (below) begin
                  speed_ff <= '0;
                  state_ff <= L_IDLE;
               end else if (full) begin
                  remap_ff <= Q16_ONE;
                  state_ff <= L_SQ;
               end else begin
                  state_ff <= L_DIV2;
               end
            end
            L_DIV2: begin
               if (div_done) begin
                  remap_ff <= {1'b0, div_quot};
                  state_ff <= L_SQ;
               end
            end
            L_SQ: begin
               sq_ff    <= sq_prod[2*FRAC_W:FRAC_W];
               state_ff <= L_GAIN;
            end
            L_GAIN: begin
               speed_ff <= neg_ff ? (SPEED_W'(0) - {1'b0, spd}) : {1'b0, spd};
               state_ff <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign speed = speed_ff;

endmodule

// ----- rtl/jtpm_merge.sv -----
// Merge stage: adds both lane speeds into the Q7.16 residues, emits whole steps.
// Holds the result register; depends on jtpm_pkg and the assertion macros.
`include "joystick_to_pointer_motion_assert.svh"

module jtpm_merge
   import jtpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  merge_cmd_type            cmd,
   input  logic [SPEED_W-1:0]       speed_x,
   input  logic [SPEED_W-1:0]       speed_y,
   input  logic                     invert_y,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [MOVE_W-1:0] rsp_move_x,
   output logic signed [MOVE_W-1:0] rsp_move_y
);

   typedef enum logic {M_IDLE, M_EMIT} state_type;

   state_type state_ff;

   logic [SPEED_W-1:0] res_x_ff, res_y_ff;
   logic [SPEED_W-1:0] sum_x_ff, sum_y_ff;
   logic [SPEED_W-1:0] sum_x_in, sum_y_in;
   logic [MOVE_W-1:0]  move_x_ff, move_y_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   logic [SPEED_W-1:0] sy_adj;
   logic [SPEED_W-1:0] bias_x, bias_y;
   logic [MOVE_W-1:0]  mx, my;
   logic [SPEED_W-1:0] frac_x, frac_y;
   logic               emit;
   logic               slot_free;
   logic               load;
   logic [MOVE_W-1:0]  res_x_int, res_y_int;

   always_comb begin
      sy_adj   = invert_y ? (SPEED_W'(0) - speed_y) : speed_y;
      sum_x_in = res_x_ff + speed_x;
      sum_y_in = res_y_ff + sy_adj;
      // Truncation toward zero: bias negative sums by one less than a step.
      bias_x = sum_x_ff + (sum_x_ff[SPEED_W-1] ? SPEED_W'(16'hFFFF) : SPEED_W'(0));
      bias_y = sum_y_ff + (sum_y_ff[SPEED_W-1] ? SPEED_W'(16'hFFFF) : SPEED_W'(0));
      mx     = bias_x[SPEED_W-1:FRAC_W];
      my     = bias_y[SPEED_W-1:FRAC_W];
      frac_x = sum_x_ff - {mx, {FRAC_W{1'b0}}};
      frac_y = sum_y_ff - {my, {FRAC_W{1'b0}}};
      emit      = (mx != '0) || (my != '0);
      slot_free = !rsp_valid_ff || rsp_ready;
      load      = (state_ff == M_EMIT) && emit && slot_free;
      // A new move takes the register; otherwise a taken item empties it.
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      res_x_int = res_x_ff[SPEED_W-1:FRAC_W];
      res_y_int = res_y_ff[SPEED_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         rsp_valid_ff <= 1'b0;
         res_x_ff     <= '0;
         res_y_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            M_IDLE: begin
               if (cmd.clear) begin
                  res_x_ff <= '0;
                  res_y_ff <= '0;
               end
               if (cmd.start) begin
                  sum_x_ff <= sum_x_in;
                  sum_y_ff <= sum_y_in;
                  state_ff <= M_EMIT;
               end
            end
            M_EMIT: begin
               if (!emit) begin
                  res_x_ff <= sum_x_ff;
                  res_y_ff <= sum_y_ff;
                  state_ff <= M_IDLE;
               end else if (slot_free) begin
                  res_x_ff  <= frac_x;
                  res_y_ff  <= frac_y;
                  move_x_ff <= mx;
                  move_y_ff <= my;
                  state_ff  <= M_IDLE;
               end
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != M_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_move_x = move_x_ff;
   assign rsp_move_y = move_y_ff;

   // Residues keep less than one whole step between items.
   `JTPM_ASSERT_ALWAYS(a_res_x_frac, (res_x_int == '0) || (res_x_int == '1))
   `JTPM_ASSERT_ALWAYS(a_res_y_frac, (res_y_int == '0) || (res_y_int == '1))
   // A result never carries a zero move on both axes.
   `JTPM_ASSERT_IMPLIES(a_move_nonzero, rsp_valid_ff, (move_x_ff != '0) || (move_y_ff != '0))

endmodule

// ----- rtl/joystick_to_pointer_motion.sv -----
// Top level of the joystick-to-pointer motion block: registers, sequencer,
// two axis lanes and the merge stage. Depends on jtpm_pkg, jtpm_lane, jtpm_merge.
//
// The block turns raw X/Y stick samples into whole-step pointer moves. The time
// a tick item (opcode tick) takes is set by the slower of the two axis lanes. In
// the longest case a lane runs two 16-step serial divisions (normalization by the
// half range, then dead-zone remap), each set up in the state before it and ended
// by the state that takes the quotient, then the square and the gain multiply.
// The sequencer then sees both lanes done, the merge stage updates the residues
// and loads the result register, and the sequencer returns to idle, where the next
// item can be accepted. A sample at or beyond the half range skips both divisions;
// a deflection inside the dead zone ends the lane after the first division. The
// two lanes work in parallel, so the Y axis costs no extra time. Pause, resume,
// ignored opcodes and ticks while paused leave the sequencer idle: the next item
// can be accepted at the following edge. One item is in flight at a time; req_ready
// is high whenever the sequencer is idle, even while an earlier result still waits
// in the output register. If a new move is ready while the output register is still
// full, the merge stage holds it until rsp_ready frees the register, and the tick
// lasts that much longer. A tick produces a result item only when either axis has
// gathered at least one whole step; pause clears the residues and suppresses results
// until resume. Configuration writes are always accepted (csr_ready is tied high)
// and must only be issued while the block is idle.
module joystick_to_pointer_motion
   import jtpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Input item channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   // Result item channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MOVE_W-1:0]   rsp_move_x,
   output logic signed [MOVE_W-1:0]   rsp_move_y,
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [1:0] {T_IDLE, T_LANES, T_MERGE} state_type;

   state_type state_ff;

   // Configuration registers.
   logic signed [SAMPLE_W-1:0] center_x_ff, center_y_ff;
   logic [SAMPLE_W-1:0]        reach_x_ff, reach_y_ff;
   logic [GAIN_W-1:0]          gain_x_ff, gain_y_ff;
   logic [FRAC_W-1:0]          deadband_ff;
   logic                       invert_y_ff;

   logic          paused_ff;
   logic          done_x_ff, done_y_ff;
   logic          accept;
   logic          lane_go;
   logic          lane_done_x, lane_done_y;
   logic          both_done;
   logic [SPEED_W-1:0] speed_x, speed_y;
   logic          merge_busy;
   merge_cmd_type merge_cmd;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         reach_x_ff  <= RST_REACH;
         reach_y_ff  <= RST_REACH;
         gain_x_ff   <= RST_GAIN_X;
         gain_y_ff   <= RST_GAIN_Y;
         deadband_ff <= RST_DEADBAND;
         invert_y_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_REACH_X:  reach_x_ff  <= csr_data;
            CSR_REACH_Y:  reach_y_ff  <= csr_data;
            CSR_GAIN_X:   gain_x_ff   <= csr_data[GAIN_W-1:0];
            CSR_GAIN_Y:   gain_y_ff   <= csr_data[GAIN_W-1:0];
            CSR_DEADBAND: deadband_ff <= csr_data;
            CSR_INVERT_Y: invert_y_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Item decode. An unused opcode is accepted and dropped.
   always_comb begin
      req_ready = (state_ff == T_IDLE);
      accept    = req_valid && req_ready;
      lane_go   = accept && (req_opcode == OP_TICK) && !paused_ff;
      both_done = (done_x_ff || lane_done_x) && (done_y_ff || lane_done_y);
      merge_cmd.start = (state_ff == T_LANES) && both_done;
      merge_cmd.clear = accept && (req_opcode == OP_PAUSE);
   end

   // Sequencer: start both lanes, wait for both, then let the merge stage finish.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         paused_ff <= 1'b0;
         done_x_ff <= 1'b0;
         done_y_ff <= 1'b0;
      end else begin
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  if (req_opcode == OP_PAUSE) begin
                     paused_ff <= 1'b1;
                  end else if (req_opcode == OP_RESUME) begin
                     paused_ff <= 1'b0;
                  end
               end
               if (lane_go) begin
                  done_x_ff <= 1'b0;
                  done_y_ff <= 1'b0;
                  state_ff  <= T_LANES;
               end
            end
            T_LANES: begin
               if (lane_done_x) begin
                  done_x_ff <= 1'b1;
               end
               if (lane_done_y) begin
                  done_y_ff <= 1'b1;
               end
               if (both_done) begin
                  state_ff <= T_MERGE;
               end
            end
            T_MERGE: begin
               if (!merge_busy) begin
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   jtpm_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_go),
      .sample   (req_sample_x),
      .center   (center_x_ff),
      .reach    (reach_x_ff),
      .gain     (gain_x_ff),
      .deadband (deadband_ff),
      .done     (lane_done_x),
      .speed    (speed_x)
   );

   jtpm_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_go),
      .sample   (req_sample_y),
      .center   (center_y_ff),
      .reach    (reach_y_ff),
      .gain     (gain_y_ff),
      .deadband (deadband_ff),
      .done     (lane_done_y),
      .speed    (speed_y)
   );

   jtpm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .cmd        (merge_cmd),
      .speed_x    (speed_x),
      .speed_y    (speed_y),
      .invert_y   (invert_y_ff),
      .busy       (merge_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_move_x (rsp_move_x),
      .rsp_move_y (rsp_move_y)
   );

endmodule
